// File: sv/f10cd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the FAST-10 corner detector.
// No dependencies; every other file of the block uses this package.
package f10cd_pkg;

  localparam int MaxWidth   = 2048;
  localparam int AddrW      = $clog2(MaxWidth);
  localparam int LineRows   = 6;
  localparam int WinSize    = 7;
  localparam int CircLen    = 16;
  localparam int ArcLength  = 10;
  localparam int FifoDepth  = 4;

  localparam logic [1:0] RegThreshold = 2'd0;
  localparam logic [1:0] RegWidth     = 2'd1;
  localparam logic [1:0] RegHeight    = 2'd2;

  localparam logic [7:0]  ThresholdRst = 8'd20;
  localparam logic [11:0] WidthRst     = 12'd640;
  localparam logic [11:0] HeightRst    = 12'd480;
  localparam logic [11:0] MinDim       = 12'd7;

  localparam logic [2:0] CircRow [CircLen] =
    '{3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
      3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
  localparam logic [2:0] CircCol [CircLen] =
    '{3'd3, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4,
      3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2};

  typedef struct packed {
    logic [7:0]  threshold;
    logic [11:0] width;
    logic [11:0] height;
  } cfg_t;

  typedef struct packed {
    logic [WinSize-1:0][7:0] px;
    logic [AddrW-1:0]        col;
    logic [11:0]             row;
  } col_entry_t;

endpackage

// File: sv/f10cd_fifo.sv
`timescale 1ns / 1ps
// Short queue of pixel columns between the front and back parts.
// Depends on f10cd_pkg for the entry type and depth.
module f10cd_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  f10cd_pkg::col_entry_t push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output f10cd_pkg::col_entry_t pop_data_o
);

  localparam int PtrW = $clog2(f10cd_pkg::FifoDepth);

  f10cd_pkg::col_entry_t mem_q [f10cd_pkg::FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;

  assign full_o     = (count_q == (PtrW+1)'(f10cd_pkg::FifoDepth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrW+1)'(f10cd_pkg::FifoDepth))
    else $error("queue count exceeds depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");

endmodule

// File: sv/f10cd_front.sv
`timescale 1ns / 1ps
// Front part: position counters, line store memory and column assembly.
// Depends on f10cd_pkg; feeds assembled columns to the queue.
module f10cd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  f10cd_pkg::cfg_t       cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            pixel_i,
  input  logic                  frame_start_i,
  output logic                  push_o,
  input  logic                  full_i,
  output f10cd_pkg::col_entry_t push_data_o
);

  localparam int AW = f10cd_pkg::AddrW;
  localparam int MW = 8 * f10cd_pkg::LineRows;

  logic [MW-1:0]  mem [f10cd_pkg::MaxWidth];
  logic [MW-1:0]  rd_q;
  logic [AW-1:0]  col_q, col_d, cur_col;
  logic [11:0]    row_q, row_d, cur_row;
  logic [11:0]    w_eff, h_eff, col_inc;
  logic [12:0]    row_inc;
  logic           accept;
  logic           s1_valid_q, s1_valid_d;
  logic [7:0]     s1_px_q;
  logic [AW-1:0]  s1_col_q;
  logic [11:0]    s1_row_q;
  logic           clr_busy_q;
  logic [AW-1:0]  clr_addr_q;
  logic [MW-1:0]  wr_word;

  assign push_o     = s1_valid_q && !full_i;
  assign in_stall_o = clr_busy_q || (s1_valid_q && full_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (cfg_i.width < f10cd_pkg::MinDim) begin
      w_eff = f10cd_pkg::MinDim;
    end else if (cfg_i.width > 12'(f10cd_pkg::MaxWidth)) begin
      w_eff = 12'(f10cd_pkg::MaxWidth);
    end else begin
      w_eff = cfg_i.width;
    end
    h_eff   = (cfg_i.height < f10cd_pkg::MinDim) ? f10cd_pkg::MinDim : cfg_i.height;
    cur_col = frame_start_i ? '0 : col_q;
    cur_row = frame_start_i ? '0 : row_q;
    col_inc = 12'(cur_col) + 12'd1;
    row_inc = {1'b0, cur_row} + 13'd1;
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      if (col_inc >= w_eff) begin
        col_d = '0;
        row_d = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[11:0];
      end else begin
        col_d = col_inc[AW-1:0];
        row_d = cur_row;
      end
    end
    s1_valid_d = accept || (s1_valid_q && !push_o);
  end

  always_comb begin
    push_data_o.px  = {s1_px_q, rd_q};
    push_data_o.col = s1_col_q;
    push_data_o.row = s1_row_q;
    wr_word         = {s1_px_q, rd_q[MW-1:8]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == AW'(f10cd_pkg::MaxWidth - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q  <= pixel_i;
      s1_col_q <= cur_col;
      s1_row_q <= cur_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (push_o) begin
      mem[s1_col_q] <= wr_word;
    end
    if (accept) begin
      if (push_o && (s1_col_q == cur_col)) begin
        rd_q <= wr_word;
      end else begin
        rd_q <= mem[cur_col];
      end
    end
  end

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> in_stall_o)
    else $error("input taken during clearing pass");
  a_clear_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s1_valid_q)
    else $error("column pending during clearing pass");

endmodule

// File: sv/f10cd_back.sv
`timescale 1ns / 1ps
// Back part: 7x7 window shift, FAST-10 segment test and result register.
// Depends on f10cd_pkg; takes columns from the queue.
module f10cd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  f10cd_pkg::cfg_t       cfg_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  input  f10cd_pkg::col_entry_t pop_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  center_valid_o,
  output logic                  is_corner_o,
  output logic [10:0]           center_col_o,
  output logic [11:0]           center_row_o
);

  localparam int N = f10cd_pkg::WinSize;

  logic [7:0]  win_q [N][N];
  logic [7:0]  win_d [N][N];
  logic [7:0]  c, p;
  logic [8:0]  hi_sum;
  logic [7:0]  hi, lo;
  logic [f10cd_pkg::CircLen-1:0] bright, dark;
  logic        arc_b, arc_d, run_b, run_d;
  logic        valid, corner;
  logic        out_valid_q;
  logic        cv_q, corner_q;
  logic [10:0] ccol_q;
  logic [11:0] crow_q;

  assign pop_o = !empty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    for (int r = 0; r < N; r++) begin
      for (int j = 0; j < N - 1; j++) begin
        win_d[r][j] = win_q[r][j+1];
      end
      win_d[r][N-1] = pop_data_i.px[r];
    end
  end

  always_comb begin
    c      = win_d[3][3];
    hi_sum = {1'b0, c} + {1'b0, cfg_i.threshold};
    hi     = hi_sum[8] ? 8'hFF : hi_sum[7:0];
    lo     = (c > cfg_i.threshold) ? c - cfg_i.threshold : 8'd0;
    for (int i = 0; i < f10cd_pkg::CircLen; i++) begin
      p         = win_d[f10cd_pkg::CircRow[i]][f10cd_pkg::CircCol[i]];
      bright[i] = (p > hi);
      dark[i]   = (p < lo);
    end
    arc_b = 1'b0;
    arc_d = 1'b0;
    for (int i = 0; i < f10cd_pkg::CircLen; i++) begin
      run_b = 1'b1;
      run_d = 1'b1;
      for (int j = 0; j < f10cd_pkg::ArcLength; j++) begin
        run_b = run_b & bright[(i + j) % f10cd_pkg::CircLen];
        run_d = run_d & dark[(i + j) % f10cd_pkg::CircLen];
      end
      arc_b = arc_b | run_b;
      arc_d = arc_d | run_d;
    end
    valid  = (pop_data_i.col >= 11'd3) && (pop_data_i.row >= 12'd3);
    corner = (pop_data_i.col >= 11'd6) && (pop_data_i.row >= 12'd6) && (arc_b || arc_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int r = 0; r < N; r++) begin
        for (int j = 0; j < N; j++) begin
          win_q[r][j] <= '0;
        end
      end
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        win_q       <= win_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cv_q     <= valid;
      corner_q <= valid && corner;
      ccol_q   <= valid ? pop_data_i.col - 11'd3 : 11'd0;
      crow_q   <= valid ? pop_data_i.row - 12'd3 : 12'd0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign center_valid_o = cv_q;
  assign is_corner_o    = corner_q;
  assign center_col_o   = ccol_q;
  assign center_row_o   = crow_q;

  a_corner_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && corner_q |-> cv_q)
    else $error("corner reported without a centre");
  a_no_center_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !cv_q |-> (ccol_q == '0) && (crow_q == '0))
    else $error("position fields not cleared without a centre");

endmodule

// File: sv/fast10_corner_detector_core.sv
`timescale 1ns / 1ps
// Top level of the FAST-10 corner detector: configuration registers and wiring.
// Depends on f10cd_pkg, f10cd_front, f10cd_fifo and f10cd_back.
//
// The core takes one 8-bit pixel per clock in raster order and returns one result
// beat per pixel, reporting on the centre three rows and three columns behind it.
// Sustained rate is one pixel per cycle while in_stall_o is low: the line store is read
// when a pixel is taken, written through its second port when the column is pushed,
// and a read of the column being written in that cycle takes the new word. A result
// passes the column register, the queue and the result register. After reset the line
// store is cleared with in_stall_o high; configuration writes are taken at any time.
module fast10_corner_detector_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pixel_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        center_valid_o,
  output logic        is_corner_o,
  output logic [10:0] center_col_o,
  output logic [11:0] center_row_o
);

  f10cd_pkg::cfg_t       cfg_q;
  f10cd_pkg::col_entry_t push_data, pop_data;
  logic                  push, full, pop, empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= f10cd_pkg::ThresholdRst;
      cfg_q.width     <= f10cd_pkg::WidthRst;
      cfg_q.height    <= f10cd_pkg::HeightRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        f10cd_pkg::RegThreshold: cfg_q.threshold <= cfg_data_i[7:0];
        f10cd_pkg::RegWidth:     cfg_q.width     <= cfg_data_i;
        f10cd_pkg::RegHeight:    cfg_q.height    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  f10cd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .push_o        (push),
    .full_i        (full),
    .push_data_o   (push_data)
  );

  f10cd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  f10cd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .empty_i        (empty),
    .pop_o          (pop),
    .pop_data_i     (pop_data),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .center_valid_o (center_valid_o),
    .is_corner_o    (is_corner_o),
    .center_col_o   (center_col_o),
    .center_row_o   (center_row_o)
  );

endmodule

// File: dv/tb_fast10_corner_detector_core.sv
`timescale 1ns / 1ps
// Testbench for fast10_corner_detector_core: streams pixel frames under several register
// settings with random gaps and stalls, and checks every result beat against a predictor.
// Depends on f10cd_pkg and the RTL of the core.
module tb_fast10_corner_detector_core;
  import f10cd_pkg::*;

  typedef struct {
    logic [7:0] pixel;
    logic       fs;
  } pixel_beat_t;

  typedef struct {
    logic        cv;
    logic        corner;
    logic [10:0] col;
    logic [11:0] row;
  } corner_res_t;

  localparam int IdleLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = RegThreshold;
  logic [11:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  pixel_i = '0;
  logic        frame_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        center_valid_o;
  logic        is_corner_o;
  logic [10:0] center_col_o;
  logic [11:0] center_row_o;

  fast10_corner_detector_core uut (.*);

  always #5 clk_i = ~clk_i;

  pixel_beat_t pend_q[$];
  corner_res_t exp_q[$];
  logic [7:0]  line_mem[6][MaxWidth];
  logic [7:0]  win[7][7];
  int unsigned cur_thr, cur_w, cur_h, col_pos, row_pos;
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          no_idle = 0;
  bit          hold_req = 0;
  int          in_gap = 0, out_gap = 0, hold_cnt = 0;
  int          dx[16] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};
  int          dy[16] = '{-3, -3, -2, -1, 0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3};

  function automatic bit has_arc(logic [15:0] mask);
    int run;
    run = 0;
    for (int i = 0; i < 32; i++) begin
      if (mask[i % 16]) begin
        run++;
        if (run >= ArcLength) return 1'b1;
      end else begin
        run = 0;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit fast10_test();
    int unsigned c, hi, lo, p;
    logic [15:0] bright, dark;
    c = win[3][3];
    hi = c + cur_thr;
    lo = (c > cur_thr) ? c - cur_thr : 0;
    bright = '0;
    dark = '0;
    if (hi > 255) hi = 255;
    for (int i = 0; i < 16; i++) begin
      p = win[3 + dy[i]][3 + dx[i]];
      bright[i] = p > hi;
      dark[i] = p < lo;
    end
    return has_arc(bright) || has_arc(dark);
  endfunction

  function automatic void predict_pixel(logic [7:0] px, logic fs);
    int unsigned w, h, ci;
    logic [7:0] column[7];
    corner_res_t res;
    w = (cur_w < 7) ? 7 : ((cur_w > MaxWidth) ? MaxWidth : cur_w);
    h = (cur_h < 7) ? 7 : cur_h;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    ci = (col_pos < MaxWidth) ? col_pos : MaxWidth - 1;
    for (int k = 0; k < 6; k++) column[k] = line_mem[k][ci];
    column[6] = px;
    for (int k = 0; k < 6; k++) line_mem[k][ci] = column[k + 1];
    for (int r = 0; r < 7; r++) begin
      for (int c = 0; c < 6; c++) win[r][c] = win[r][c + 1];
      win[r][6] = column[r];
    end
    res.cv = (col_pos >= 3) && (row_pos >= 3);
    res.corner = res.cv && col_pos >= 6 && row_pos >= 6 && fast10_test();
    res.col = res.cv ? 11'(col_pos - 3) : '0;
    res.row = res.cv ? 12'(row_pos - 3) : '0;
    exp_q = {exp_q, res};
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
    row_pos = row_pos & 12'hFFF;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_beat_t item;
    bit          busy;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        predict_pixel(pixel_i, frame_start_i);
        busy = 0;
      end
      if (!busy) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pend_q.size() > 0) begin
          item = pend_q.pop_front();
          in_valid_i <= 1'b1;
          pixel_i <= item.pixel;
          frame_start_i <= item.fs;
          in_gap <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    corner_res_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Result beat with no expectation at %0t", $realtime);
        end else begin
          e = exp_q.pop_front();
          if (center_valid_o !== e.cv || is_corner_o !== e.corner ||
              center_col_o !== e.col || center_row_o !== e.row) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch at %0t: expected cv=%0d corner=%0d col=%0d row=%0d, got cv=%0d corner=%0d col=%0d row=%0d",
                       $realtime, e.cv, e.corner, e.col, e.row, center_valid_o,
                       is_corner_o, center_col_o, center_row_o);
          end
        end
      end
      if (hold_req && hold_cnt == 0) begin
        hold_cnt <= 200;
        hold_req <= 0;
        out_stall_i <= 1'b1;
      end else if (hold_cnt > 1) begin
        hold_cnt <= hold_cnt - 1;
        out_stall_i <= 1'b1;
      end else if (hold_cnt == 1) begin
        hold_cnt <= 0;
        out_stall_i <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        out_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_fast10_corner_detector_core failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [11:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    case (idx)
      RegThreshold: cur_thr = data[7:0];
      RegWidth:     cur_w = data;
      default:      cur_h = data;
    endcase
  endtask

  task automatic set_regs(int thr, int w, int h);
    write_reg(RegThreshold, 12'(thr));
    write_reg(RegWidth, 12'(w));
    write_reg(RegHeight, 12'(h));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pend_q.size() > 0 || in_valid_i || exp_q.size() > 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic push_dot_frame(logic [7:0] bg, logic [7:0] dot);
    pixel_beat_t b;
    for (int i = 0; i < 49; i++) begin
      b.pixel = (i == 24) ? dot : bg;
      b.fs = (i == 0);
      pend_q = {pend_q, b};
    end
  endtask

  task automatic push_random(int n);
    pixel_beat_t b;
    int base;
    base = $urandom_range(0, 255);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) b.pixel = $urandom_range(0, 255);
      else b.pixel = 8'((base + $urandom_range(0, 3)) & 255);
      b.fs = ($urandom_range(0, 59) == 0);
      pend_q = {pend_q, b};
    end
  endtask

  int phase_thr[7] = '{20, 255, 10, 30, 5, 40, 0};
  int phase_w[7]   = '{8, 7, 3, 2048, 4095, 12, 9};
  int phase_h[7]   = '{9, 0, 4095, 7, 8, 10, 7};
  int phase_n[7]   = '{110, 60, 100, 60, 60, 120, 110};

  initial begin
    cur_thr = ThresholdRst;
    cur_w = WidthRst;
    cur_h = HeightRst;
    col_pos = 0;
    row_pos = 0;
    foreach (line_mem[k, c]) line_mem[k][c] = '0;
    foreach (win[r, c]) win[r][c] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_regs(0, 7, 7);
    push_dot_frame(8'd0, 8'd255);
    push_dot_frame(8'd255, 8'd0);
    drain();
    for (int p = 0; p < 7; p++) begin
      set_regs(phase_thr[p], phase_w[p], phase_h[p]);
      no_idle = (p % 3 == 2);
      push_random(phase_n[p]);
      if (p == 5) hold_req = 1;
      drain();
    end
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && exp_q.size() == 0) begin
      $display("tb_fast10_corner_detector_core passed");
    end else begin
      $display("tb_fast10_corner_detector_core failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/f10cd_pkg.sv
sv/f10cd_fifo.sv
sv/f10cd_front.sv
sv/f10cd_back.sv
sv/fast10_corner_detector_core.sv
dv/tb_fast10_corner_detector_core.sv
